// ===== hdl/mexp_pkg.sv =====
// mexp_pkg: shared types and constants for the modular exponentiation unit.
// No dependencies; imported by mexp_modmul and modular_exponentiation_unit.
package mexp_pkg;

  localparam int unsigned WordW     = 32;  // exponent, modulus, power
  localparam int unsigned BaseW     = 33;  // packed cipher value
  localparam int unsigned ProdW     = 2 * WordW;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ExpWidthDefault = 32;

  localparam logic [WordW-1:0] ExpReset = 32'd1921821779;
  localparam logic [WordW-1:0] ModReset = 32'd4294434817;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgExponent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgModulus  = 1'b1;

  // command to the shared multiply/reduce unit
  typedef struct packed {
    logic start;  // launch one operation
    logic raw;    // reduce the raw base instead of a product
  } mexp_cmd_t;

  typedef enum logic [0:0] {
    UnitIdle,
    UnitReduce
  } mexp_unit_e;

  typedef enum logic [2:0] {
    StIdle,
    StBase,
    StBit,
    StMulAcc,
    StSquare
  } mexp_state_e;

endpackage

// ===== hdl/mexp_modmul.sv =====
// mexp_modmul: shared modular multiplier, one 32x32 product then a
// bit-serial restoring reduction of 32 steps. Depends on mexp_pkg.
module mexp_modmul
  import mexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mexp_cmd_t           cmd_i,
  input  logic [WordW-1:0]    a_i,
  input  logic [WordW-1:0]    b_i,
  input  logic [WordW-1:0]    m_i,
  input  logic [BaseW-1:0]    raw_i,
  output logic                done_o,
  output logic [WordW-1:0]    res_o
);

  localparam int unsigned StepW = $clog2(WordW);

  mexp_unit_e       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] p_q;
  logic [ProdW-1:0] prod;
  logic [WordW:0]   t;
  logic [WordW+1:0] diff;
  logic [WordW-1:0] r_new;

  // p_q holds {remainder, unconsumed low bits}; high half starts below m
  assign prod  = a_i * b_i;
  assign t     = p_q[ProdW-1:WordW-1];
  assign diff  = {1'b0, t} - {2'b00, m_i};
  assign r_new = diff[WordW+1] ? t[WordW-1:0] : diff[WordW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      UnitIdle: begin
        if (cmd_i.start) begin
          state_d = UnitReduce;
          cnt_d   = '0;
        end
      end
      UnitReduce: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(WordW - 1)) begin
          state_d = UnitIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = UnitIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UnitIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == UnitIdle && cmd_i.start) begin
      p_q <= cmd_i.raw ? {{(ProdW-BaseW){1'b0}}, raw_i} : prod;
    end else if (state_q == UnitReduce) begin
      p_q <= {r_new, p_q[WordW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = p_q[ProdW-1:WordW];

endmodule

// ===== hdl/modular_exponentiation_unit.sv =====
// modular_exponentiation_unit: power = base ^ exponent mod modulus.
// Depends on mexp_pkg and mexp_modmul.
//
// Usage:
//   Command channel: drive base_i and raise start_i; the word is taken at a
//   rising edge where start_i is high and busy_o is low. busy_o stays high
//   until the result has been delivered.
//   Result channel: power_o is valid for exactly one cycle, marked by done_o.
//   The receiver cannot stall; it must take the word in that cycle.
//   Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 exponent, 1 modulus) at the clock edge, no wait states. Only write
//   while busy_o is low. Only the low EXPONENT_WIDTH exponent bits are used.
//
// Timing:
//   One shared modular multiplier (a product load, then a bit-serial
//   reduction, result registered) does all the work. Base reduction
//   takes one unit pass, then each exponent bit costs a pass through
//   the StBit state plus a square and, on a one bit, a multiply; the
//   last bit skips its square.
//   A zero base or a modulus below two returns 0 the cycle after start.
//
// Reset: asynchronous, active low; restores the default key registers and
// returns the sequencer to idle. No clearing pass is needed.
module modular_exponentiation_unit
  import mexp_pkg::*;
#(
  parameter int unsigned EXPONENT_WIDTH = ExpWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [BaseW-1:0]    base_i,
  output logic                done_o,
  output logic [WordW-1:0]    power_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_wdata_i
);

  localparam int unsigned BitW = $clog2(EXPONENT_WIDTH);

  // config registers
  logic [EXPONENT_WIDTH-1:0] exp_q;
  logic [WordW-1:0]          mod_q;

  // sequencer state and working values
  mexp_state_e               state_q, state_d;
  logic [BitW-1:0]           bit_q;
  logic [EXPONENT_WIDTH-1:0] e_sh_q;   // exponent, shifted right per bit
  logic [WordW-1:0]          acc_q;    // running result
  logic [WordW-1:0]          sq_q;     // base^(2^k) mod m
  logic [WordW-1:0]          power_q;
  logic                      done_q;

  logic                      trivial;
  logic                      last_bit;
  logic                      finish;
  logic [WordW-1:0]          finish_val;
  logic                      use_acc;
  mexp_cmd_t                 cmd;
  logic                      unit_done;
  logic [WordW-1:0]          unit_res;

  // zero base, or modulus 0 or 1, always gives zero
  assign trivial  = (base_i == '0) || (mod_q[WordW-1:1] == '0);
  assign last_bit = (bit_q == BitW'(EXPONENT_WIDTH - 1));
  // multiply acc*sq on a one bit, else square sq*sq
  assign use_acc  = (state_q == StBit) && e_sh_q[0];

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    finish     = 1'b0;
    finish_val = acc_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && !trivial) begin
          cmd.start = 1'b1;
          cmd.raw   = 1'b1;
          state_d   = StBase;
        end
      end
      StBase: begin
        if (unit_done) begin
          state_d = StBit;
        end
      end
      StBit: begin
        if (e_sh_q[0]) begin
          cmd.start = 1'b1;
          state_d   = StMulAcc;
        end else if (last_bit) begin
          // top bit clear: nothing left to multiply in
          finish  = 1'b1;
          state_d = StIdle;
        end else begin
          cmd.start = 1'b1;
          state_d   = StSquare;
        end
      end
      StMulAcc: begin
        if (unit_done) begin
          if (last_bit) begin
            finish     = 1'b1;
            finish_val = unit_res;
            state_d    = StIdle;
          end else begin
            cmd.start = 1'b1;
            state_d   = StSquare;
          end
        end
      end
      StSquare: begin
        if (unit_done) begin
          state_d = StBit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bit_q   <= '0;
      done_q  <= 1'b0;
      exp_q   <= ExpReset[EXPONENT_WIDTH-1:0];
      mod_q   <= ModReset;
    end else begin
      state_q <= state_d;
      done_q  <= finish || (state_q == StIdle && start_i && trivial);
      if (state_q == StIdle) begin
        bit_q <= '0;
      end else if (state_q == StSquare && unit_done) begin
        bit_q <= bit_q + 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgExponent) begin
          exp_q <= cfg_wdata_i[EXPONENT_WIDTH-1:0];
        end else if (cfg_idx_i == CfgModulus) begin
          mod_q <= cfg_wdata_i;
        end
      end
    end
  end

  // working values: no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      e_sh_q  <= exp_q;
      acc_q   <= WordW'(1);   // 1 mod m, m >= 2 on this path
    end
    if (state_q == StBase && unit_done) begin
      sq_q <= unit_res;
    end
    if (state_q == StMulAcc && unit_done) begin
      acc_q <= unit_res;
    end
    if (state_q == StSquare && unit_done) begin
      sq_q   <= unit_res;
      e_sh_q <= e_sh_q >> 1;
    end
    if (finish) begin
      power_q <= finish_val;
    end else if (state_q == StIdle && start_i && trivial) begin
      power_q <= '0;
    end
  end

  mexp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (use_acc ? acc_q : sq_q),
    .b_i    (sq_q),
    .m_i    (mod_q),
    .raw_i  (base_i),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  assign busy_o  = (state_q != StIdle);
  assign done_o  = done_q;
  assign power_o = power_q;

endmodule
